FILE: hdl/udrb_pkg.sv
// Shared types and constants for the UART dual ring buffer.
package udrb_pkg;

    // Fixed widths of the byte path and of the reported levels.
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 9;

    // Byte returned when a pop finds its buffer empty.
    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

    // Event codes carried by a request beat.
    typedef enum logic [1:0] {
        MODE_LINE_RX  = 2'd0,
        MODE_SW_READ  = 2'd1,
        MODE_SW_WRITE = 2'd2,
        MODE_TX_READY = 2'd3
    } mode_t;

    // Status codes carried by a response beat.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_RX_DROPPED  = 3'd1,
        ST_RX_EMPTY    = 3'd2,
        ST_TX_REJECTED = 3'd3,
        ST_TX_IDLE     = 3'd4
    } status_t;

    // Source of the read_data field of a response.
    typedef enum logic [1:0] {
        RD_ZERO  = 2'd0,
        RD_EMPTY = 2'd1,
        RD_RX    = 2'd2,
        RD_TX    = 2'd3
    } rd_src_t;

    typedef struct packed {
        mode_t              mode;
        logic [BYTE_W-1:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        status_t            status;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] tx_free;
        logic               tx_irq_enable;
    } rsp_t;

endpackage

FILE: hdl/udrb_ram.sv
// Byte-wide simple dual-port RAM with one write port and a registered read port.
module udrb_ram
    import udrb_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/udrb_ring.sv
// One ring buffer: head and tail pointers, occupancy count and the byte RAM.
module udrb_ring
    import udrb_pkg::*;
#(
    parameter int DEPTH = 256
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [BYTE_W-1:0]            push_data,
    input  logic                         pop,
    output logic [BYTE_W-1:0]            pop_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level_next
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // Pointer advance with wrap at the last entry.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next  = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    assign level_next = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage; a pop reads the head entry, the byte appears next cycle.
    udrb_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (push_data),
        .re    (pop),
        .raddr (head_reg),
        .rdata (pop_data)
    );

endmodule

FILE: hdl/uart_dual_ring_buffer.sv
// Top level of the UART receive and transmit ring buffers.
// Each request beat is one event: a line byte pushed into the receive buffer, a
// software read popping it, a software write pushing the transmit buffer (which
// also sets the transmit interrupt enable), or a transmitter request popping it
// (clearing the enable when the buffer is empty). One request beat is taken per
// cycle and its response beat is valid the following cycle; its read data comes
// from the registered read port of each buffer RAM. A new request is taken
// in the same cycle the previous response leaves, and is held off only while a
// response waits under stall. The RAMs need no clearing after reset: the counts
// allow a pop only of an entry that was written.
module uart_dual_ring_buffer
    import udrb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
)(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    logic accept;

    logic             rx_push, rx_pop, rx_full, rx_empty;
    logic             tx_push, tx_pop, tx_full, tx_empty;
    logic [BYTE_W-1:0] rx_pop_data, tx_pop_data;
    logic [CNT_W-1:0] rx_level_next, tx_level_next, tx_free_next;

    logic    rsp_valid_reg, rsp_valid_next;
    logic    tx_irq_reg, tx_irq_next;
    status_t status_reg, status_next;
    rd_src_t rd_src_reg, rd_src_next;
    logic [LEVEL_W-1:0] rx_level_reg, tx_level_reg, tx_free_reg;

    // Handshake: take a request unless a response is held under stall.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Event decode into buffer operations and status.
    always_comb
    begin
        rx_push     = 1'b0;
        rx_pop      = 1'b0;
        tx_push     = 1'b0;
        tx_pop      = 1'b0;
        tx_irq_next = tx_irq_reg;
        status_next = ST_OK;
        rd_src_next = RD_ZERO;
        if (accept)
        begin
            unique case (req.mode)
                MODE_LINE_RX:
                begin
                    if (rx_full)
                    begin
                        status_next = ST_RX_DROPPED;
                    end
                    else
                    begin
                        rx_push = 1'b1;
                    end
                end
                MODE_SW_READ:
                begin
                    if (rx_empty)
                    begin
                        status_next = ST_RX_EMPTY;
                        rd_src_next = RD_EMPTY;
                    end
                    else
                    begin
                        rx_pop      = 1'b1;
                        rd_src_next = RD_RX;
                    end
                end
                MODE_SW_WRITE:
                begin
                    if (tx_full)
                    begin
                        status_next = ST_TX_REJECTED;
                    end
                    else
                    begin
                        tx_push     = 1'b1;
                        tx_irq_next = 1'b1;
                    end
                end
                MODE_TX_READY:
                begin
                    if (tx_empty)
                    begin
                        status_next = ST_TX_IDLE;
                        rd_src_next = RD_EMPTY;
                        tx_irq_next = 1'b0;
                    end
                    else
                    begin
                        tx_pop      = 1'b1;
                        rd_src_next = RD_TX;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    // Receive and transmit buffers.
    udrb_ring #(
        .DEPTH (BUFFER_DEPTH)
    ) u_rx_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (rx_push),
        .push_data  (req.data_byte),
        .pop        (rx_pop),
        .pop_data   (rx_pop_data),
        .full       (rx_full),
        .empty      (rx_empty),
        .level_next (rx_level_next)
    );

    udrb_ring #(
        .DEPTH (BUFFER_DEPTH)
    ) u_tx_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (tx_push),
        .push_data  (req.data_byte),
        .pop        (tx_pop),
        .pop_data   (tx_pop_data),
        .full       (tx_full),
        .empty      (tx_empty),
        .level_next (tx_level_next)
    );

    assign tx_free_next = DEPTH_CNT - tx_level_next;

    // Response valid: set on a request, cleared once the beat is taken.
    always_comb
    begin
        priority if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            tx_irq_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            tx_irq_reg    <= tx_irq_next;
        end
    end

    // Response payload, captured with the request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            rd_src_reg   <= rd_src_next;
            rx_level_reg <= LEVEL_W'(rx_level_next);
            tx_level_reg <= LEVEL_W'(tx_level_next);
            tx_free_reg  <= LEVEL_W'(tx_free_next);
        end
    end

    // Read data: zero, the empty byte, or straight from the RAM read registers.
    always_comb
    begin
        unique case (rd_src_reg)
            RD_ZERO:  rsp.read_data = '0;
            RD_EMPTY: rsp.read_data = EMPTY_BYTE;
            RD_RX:    rsp.read_data = rx_pop_data;
            RD_TX:    rsp.read_data = tx_pop_data;
            default:  rsp.read_data = '0;
        endcase
    end

    assign rsp.status        = status_reg;
    assign rsp.rx_level      = rx_level_reg;
    assign rsp.tx_level      = tx_level_reg;
    assign rsp.tx_free       = tx_free_reg;
    assign rsp.tx_irq_enable = tx_irq_reg;
    assign rsp_valid         = rsp_valid_reg;

endmodule
